>>> rtl/evdt_pkg.sv
// ----------------------------------------------------------------------------
// evdt_pkg
// Shared types and codes for the exact vector dedup table.
// ----------------------------------------------------------------------------
package evdt_pkg;

   typedef enum logic [0:0] {
      ACT_PUSH  = 1'b0,
      ACT_CLEAR = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_MATCH = 2'd0,
      STATUS_NEW   = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_LONG  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SEARCH,
      ST_RESULT
   } state_type;

endpackage

>>> rtl/evdt_ram.sv
// ----------------------------------------------------------------------------
// evdt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module evdt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/exact_vector_dedup_table.sv
// ----------------------------------------------------------------------------
// exact_vector_dedup_table
// Exact-match deduplication of word vectors within a batch.
// ----------------------------------------------------------------------------
// Input channel req_*: one transfer per vector word (req_action push) with
// req_last on the final word, or one clear transfer (req_action clear) that
// empties the table, drops a partial vector and restarts vector numbering.
// Result channel rsp_*: one transfer per vector, giving its number in the
// batch, the index of the equal stored entry (or the new entry) and a status.
// One item at a time: req_ready is high only while the sequencer is idle.
// A shared compare unit walks the stored entries, one entry read per cycle
// from the word and length memories. A push word is compared with every
// stored entry (no walk with an empty table or an overlong vector). A last
// word adds a length search over the stored entries, then the result is shown.
// The result is held in an output register until rsp_ready; no new item is
// accepted meanwhile. Synchronous reset empties the table at once; the
// memories need no clearing pass since entries are only read below the fill
// count.
// ----------------------------------------------------------------------------
module exact_vector_dedup_table #(
   parameter int MAX_ENTRIES = 16,
   parameter int MAX_LEN     = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [15:0] req_word,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_vector_number,
   output logic [3:0]  rsp_group_index,
   output logic [1:0]  rsp_status
);

   import evdt_pkg::*;

   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int WORD_DEPTH = 2 ** (EW + PW);
   localparam int LEN_DEPTH  = 2 ** EW;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [15:0]             batch_ff, batch_in;
   logic [LW-1:0]           pos_ff, pos_in;
   logic                    ovl_ff, ovl_in;
   logic [MAX_ENTRIES-1:0]  flags_ff, flags_in;
   logic [15:0]             word_ff, word_in;
   logic                    last_ff, last_in;
   logic [PW-1:0]           rd_pos_ff, rd_pos_in;
   logic [CW-1:0]           iss_ff, iss_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [EW-1:0]           cmp_idx_ff, cmp_idx_in;
   logic [15:0]             out_num_ff, out_num_in;
   logic [3:0]              out_grp_ff, out_grp_in;
   status_type              out_status_ff, out_status_in;

   logic                    wr_word_en;
   logic                    wr_len_en;
   logic                    iss_more;
   logic                    has_room;
   logic [15:0]             word_rd;
   logic [LW-1:0]           len_rd;

   assign iss_more = (iss_ff < count_ff);
   assign has_room = (count_ff < CW'(MAX_ENTRIES));

   evdt_ram #(
      .WIDTH (16),
      .DEPTH (WORD_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_word_en),
      .wr_addr ({count_ff[EW-1:0], pos_ff[PW-1:0]}),
      .wr_data (req_word),
      .rd_addr ({iss_ff[EW-1:0], rd_pos_ff}),
      .rd_data (word_rd)
   );

   evdt_ram #(
      .WIDTH (LW),
      .DEPTH (LEN_DEPTH)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (wr_len_en),
      .wr_addr (count_ff[EW-1:0]),
      .wr_data (pos_ff),
      .rd_addr (iss_ff[EW-1:0]),
      .rd_data (len_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         batch_ff   <= '0;
         pos_ff     <= '0;
         ovl_ff     <= 1'b0;
         flags_ff   <= '1;
         iss_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         batch_ff   <= batch_in;
         pos_ff     <= pos_in;
         ovl_ff     <= ovl_in;
         flags_ff   <= flags_in;
         iss_ff     <= iss_in;
         cmp_vld_ff <= cmp_vld_in;
      end
      word_ff       <= word_in;
      last_ff       <= last_in;
      rd_pos_ff     <= rd_pos_in;
      cmp_idx_ff    <= cmp_idx_in;
      out_num_ff    <= out_num_in;
      out_grp_ff    <= out_grp_in;
      out_status_ff <= out_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      batch_in      = batch_ff;
      pos_in        = pos_ff;
      ovl_in        = ovl_ff;
      flags_in      = flags_ff;
      word_in       = word_ff;
      last_in       = last_ff;
      rd_pos_in     = rd_pos_ff;
      iss_in        = iss_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = iss_ff[EW-1:0];
      out_num_in    = out_num_ff;
      out_grp_in    = out_grp_ff;
      out_status_in = out_status_ff;
      wr_word_en    = 1'b0;
      wr_len_en     = 1'b0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            iss_in    = '0;
            if (req_valid) begin
               if (req_action == ACT_CLEAR) begin
                  count_in = '0;
                  batch_in = '0;
                  flags_in = '1;
                  pos_in   = '0;
                  ovl_in   = 1'b0;
               end else begin
                  word_in = req_word;
                  last_in = req_last;
                  if (pos_ff >= LW'(MAX_LEN)) begin
                     ovl_in   = 1'b1;
                     state_in = req_last ? ST_SEARCH : ST_IDLE;
                  end else begin
                     wr_word_en = has_room;
                     rd_pos_in  = pos_ff[PW-1:0];
                     pos_in     = pos_ff + LW'(1);
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end else begin
                        state_in = req_last ? ST_SEARCH : ST_IDLE;
                     end
                  end
               end
            end
         end

         ST_SCAN: begin
            if (iss_more) begin
               iss_in = iss_ff + CW'(1);
            end
            cmp_vld_in = iss_more;
            if (cmp_vld_ff && flags_ff[cmp_idx_ff] &&
                ((len_rd <= LW'(rd_pos_ff)) || (word_rd != word_ff))) begin
               flags_in[cmp_idx_ff] = 1'b0;
            end
            if (!iss_more && !cmp_vld_ff) begin
               iss_in   = '0;
               state_in = last_ff ? ST_SEARCH : ST_IDLE;
            end
         end

         ST_SEARCH: begin
            out_num_in = batch_ff;
            if (ovl_ff) begin
               out_grp_in    = '0;
               out_status_in = STATUS_LONG;
               state_in      = ST_RESULT;
            end else if (cmp_vld_ff && flags_ff[cmp_idx_ff] && (len_rd == pos_ff)) begin
               out_grp_in    = 4'(cmp_idx_ff);
               out_status_in = STATUS_MATCH;
               state_in      = ST_RESULT;
            end else if (!iss_more && !cmp_vld_ff) begin
               if (has_room) begin
                  wr_len_en     = 1'b1;
                  out_grp_in    = 4'(count_ff[EW-1:0]);
                  out_status_in = STATUS_NEW;
                  count_in      = count_ff + CW'(1);
               end else begin
                  out_grp_in    = '0;
                  out_status_in = STATUS_FULL;
               end
               state_in = ST_RESULT;
            end else begin
               if (iss_more) begin
                  iss_in = iss_ff + CW'(1);
               end
               cmp_vld_in = iss_more;
            end
         end

         ST_RESULT: begin
            rsp_valid = 1'b1;
            iss_in    = '0;
            if (rsp_ready) begin
               if (batch_ff != 16'hFFFF) begin
                  batch_in = batch_ff + 16'd1;
               end
               flags_in = '1;
               pos_in   = '0;
               ovl_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_vector_number = out_num_ff;
   assign rsp_group_index   = out_grp_ff;
   assign rsp_status        = out_status_ff;

`ifndef SYNTH
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result side active together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LW'(MAX_LEN))
      else $error("word position beyond vector limit");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_CLEAR)
      |=> (count_ff == '0) && (batch_ff == '0) && (pos_ff == '0))
      else $error("clear transfer did not empty the table");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> (pos_ff == '0) && !ovl_ff && (&flags_ff))
      else $error("vector state not restarted after result transfer");
`endif

endmodule

>>> test/tb_exact_vector_dedup_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exact_vector_dedup_table
// Self-checking bench for the exact vector dedup table.
// ----------------------------------------------------------------------------
// A table of directed words comes first: extremes, matches, shorter stored
// entries and clears with and without a partial vector. A fixed sequence then
// fills the table past full and sends vectors of exactly the maximum length
// and one word beyond it. Random batches follow. They repeat, trim, extend or
// alter earlier vectors so that matches happen, and they break some vectors
// off with a clear. The run ends with a run of identical vectors sent back
// to back with no idling on either side. Every result is compared field by
// field with a local model of the table or with the result written in its
// directed row. Both channels stall in random bursts, and at one point the
// result side holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_exact_vector_dedup_table;
   import evdt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int VECTOR_MAX  = 64;
   localparam int VEC_BUF     = 68;
   localparam int POOL_SIZE   = 16;
   localparam int RANDOM_ITEMS = 800;
   localparam int STEADY_VECTORS = 100;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [15:0] vector_number;
      logic [3:0]  group_index;
      status_type  status;
   } dedup_result_type;

   typedef struct {
      action_type       act;
      logic [15:0]      word;
      logic             last;
      bit               typed;
      dedup_result_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [15:0] req_word = 16'h0000;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_vector_number;
   logic [3:0]  rsp_group_index;
   logic [1:0]  rsp_status;

   // model of the table
   logic [15:0] table_words [TABLE_DEPTH][VECTOR_MAX];
   int          table_lengths [TABLE_DEPTH];
   int          table_fill;
   bit          still_equal [TABLE_DEPTH];
   int          word_pos;
   bit          overlong;
   int          vector_count;

   dedup_result_type expected_results [$];
   directed_row_type directed_rows [$];
   dedup_result_type rsp_want;

   logic [15:0] vec_buf [VEC_BUF];
   int          vec_len;
   logic [15:0] pool_words [POOL_SIZE][VEC_BUF];
   int          pool_len [POOL_SIZE];
   int          pool_fill;

   int error_count;
   int items_sent;
   int clears_sent;
   int results_seen;
   int status_hits [4];
   int stalled_cycles;
   int hold_left;
   bit long_hold_done;
   bit rx_idling;
   int rx_mode_left;
   bit tx_idling;
   int tx_mode_left;
   bit steady_phase;

   exact_vector_dedup_table u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_word          (req_word),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vector_number (rsp_vector_number),
      .rsp_group_index   (rsp_group_index),
      .rsp_status        (rsp_status)
   );

   always #5 clock = ~clock;

   function automatic void restart_vector();
      for (int e = 0; e < TABLE_DEPTH; e++) still_equal[e] = 1'b1;
      word_pos = 0;
      overlong = 1'b0;
   endfunction

   function automatic bit predict_dedup(input action_type act, input logic [15:0] w,
                                        input logic lst, output dedup_result_type res);
      int  e;
      int  grp;
      bit  found;
      grp = 0;
      found = 1'b0;
      res = '0;
      if (act == ACT_CLEAR) begin
         table_fill = 0;
         vector_count = 0;
         restart_vector();
         return 1'b0;
      end
      if (word_pos >= VECTOR_MAX) begin
         overlong = 1'b1;
      end else begin
         for (e = 0; e < table_fill; e++) begin
            if (still_equal[e] &&
                (table_lengths[e] <= word_pos || table_words[e][word_pos] != w))
               still_equal[e] = 1'b0;
         end
         if (table_fill < TABLE_DEPTH) table_words[table_fill][word_pos] = w;
         word_pos++;
      end
      if (!lst) return 1'b0;
      res.vector_number = vector_count[15:0];
      if (overlong) begin
         res.status = STATUS_LONG;
      end else begin
         for (e = 0; e < table_fill && !found; e++) begin
            if (still_equal[e] && table_lengths[e] == word_pos) begin
               grp = e;
               found = 1'b1;
            end
         end
         if (found) begin
            res.status = STATUS_MATCH;
         end else if (table_fill < TABLE_DEPTH) begin
            table_lengths[table_fill] = word_pos;
            grp = table_fill;
            table_fill++;
            res.status = STATUS_NEW;
         end else begin
            res.status = STATUS_FULL;
         end
      end
      res.group_index = grp[3:0];
      if (vector_count < 65535) vector_count++;
      restart_vector();
      return 1'b1;
   endfunction

   function automatic logic [15:0] random_word();
      logic [15:0] corner [4];
      corner[0] = 16'h0000;
      corner[1] = 16'h0001;
      corner[2] = 16'hFFFF;
      corner[3] = 16'h8000;
      if ($urandom_range(0, 1) == 0) return corner[$urandom_range(0, 3)];
      return 16'($urandom);
   endfunction

   function automatic void add_row(input action_type act, input logic [15:0] w,
                                   input logic lst, input bit typed = 1'b0,
                                   input logic [15:0] vn = '0, input logic [3:0] gi = '0,
                                   input status_type st = STATUS_MATCH);
      directed_row_type row;
      row.act = act;
      row.word = w;
      row.last = lst;
      row.typed = typed;
      row.want.vector_number = vn;
      row.want.group_index = gi;
      row.want.status = st;
      directed_rows = {directed_rows, row};
   endfunction

   task automatic send_item(input action_type act, input logic [15:0] w, input logic lst,
                            input bit typed = 1'b0, input dedup_result_type typed_res = '0);
      dedup_result_type predicted;
      if (tx_mode_left == 0) begin
         tx_idling = 1'($urandom_range(0, 1));
         tx_mode_left = $urandom_range(20, 150);
      end
      tx_mode_left--;
      if (!steady_phase && tx_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_word   <= w;
      req_last   <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (act == ACT_CLEAR) clears_sent++;
      if (predict_dedup(act, w, lst, predicted))
         expected_results = {expected_results, (typed ? typed_res : predicted)};
   endtask

   task automatic send_vector(input int abort_at);
      int k;
      if (abort_at < 0) begin
         for (k = 0; k < vec_len; k++) send_item(ACT_PUSH, vec_buf[k], k == vec_len - 1);
      end else begin
         for (k = 0; k < abort_at; k++) send_item(ACT_PUSH, vec_buf[k], 1'b0);
         send_item(ACT_CLEAR, random_word(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // result side: check each transfer, then pick the next ready value
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            status_hits[rsp_status]++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: vector_number %0d group_index %0d status %0d",
                      rsp_vector_number, rsp_group_index, rsp_status);
               error_count++;
            end else begin
               rsp_want = expected_results.pop_front();
               if (rsp_vector_number !== rsp_want.vector_number) begin
                  $error("vector_number: expected %0d, actual %0d",
                         rsp_want.vector_number, rsp_vector_number);
                  error_count++;
               end
               if (rsp_group_index !== rsp_want.group_index) begin
                  $error("group_index: expected %0d, actual %0d",
                         rsp_want.group_index, rsp_group_index);
                  error_count++;
               end
               if (rsp_status !== rsp_want.status) begin
                  $error("status: expected %0d, actual %0d", rsp_want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (rx_mode_left == 0) begin
            rx_idling = 1'($urandom_range(0, 1));
            rx_mode_left = $urandom_range(50, 300);
         end
         rx_mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 60) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (!steady_phase && rx_idling && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == STALL_LIMIT) begin
         $error("no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   initial begin
      int i;
      int k;
      int p;
      int pick;
      int random_goal;
      bit paused_once;
      table_fill = 0;
      vector_count = 0;
      restart_vector();
      pool_fill = 0;
      paused_once = 1'b0;

      add_row(ACT_PUSH,  16'h0000, 1'b1, 1'b1, 16'd0, 4'd0, STATUS_NEW);
      add_row(ACT_PUSH,  16'hFFFF, 1'b1, 1'b1, 16'd1, 4'd1, STATUS_NEW);
      add_row(ACT_PUSH,  16'h0000, 1'b1, 1'b1, 16'd2, 4'd0, STATUS_MATCH);
      add_row(ACT_PUSH,  16'hFFFF, 1'b0);
      add_row(ACT_PUSH,  16'h0000, 1'b1);
      add_row(ACT_PUSH,  16'hFFFF, 1'b1);
      add_row(ACT_PUSH,  16'hFFFF, 1'b0);
      add_row(ACT_PUSH,  16'h0000, 1'b0);
      add_row(ACT_PUSH,  16'h0001, 1'b1);
      add_row(ACT_CLEAR, 16'hFFFF, 1'b1);
      add_row(ACT_PUSH,  16'h1234, 1'b0);
      add_row(ACT_CLEAR, 16'h0000, 1'b0);
      add_row(ACT_PUSH,  16'h5A5A, 1'b1, 1'b1, 16'd0, 4'd0, STATUS_NEW);
      add_row(ACT_PUSH,  16'h8000, 1'b0);
      add_row(ACT_PUSH,  16'h7FFF, 1'b1);
      add_row(ACT_PUSH,  16'h8000, 1'b0);
      add_row(ACT_PUSH,  16'h7FFF, 1'b1);
      add_row(ACT_PUSH,  16'h8000, 1'b0);
      add_row(ACT_PUSH,  16'h7FFE, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_item(directed_rows[r].act, directed_rows[r].word, directed_rows[r].last,
                   directed_rows[r].typed, directed_rows[r].want);

      // fill past full, then overlong and maximum-length vectors
      send_item(ACT_CLEAR, random_word(), 1'($urandom_range(0, 1)));
      for (i = 0; i < TABLE_DEPTH + 2; i++) send_item(ACT_PUSH, 16'h4000 + 16'(i), 1'b1);
      vec_len = VECTOR_MAX + 2;
      for (k = 0; k < vec_len; k++) vec_buf[k] = random_word();
      send_vector(-1);
      vec_len = 1;
      vec_buf[0] = 16'h4005;
      send_vector(-1);
      send_item(ACT_CLEAR, random_word(), 1'($urandom_range(0, 1)));
      vec_len = VECTOR_MAX;
      for (k = 0; k < vec_len; k++) vec_buf[k] = random_word();
      send_vector(-1);
      send_vector(-1);
      vec_len = VECTOR_MAX + 1;
      vec_buf[VECTOR_MAX] = random_word();
      send_vector(-1);
      wait_results_drained();

      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         if ($urandom_range(0, 99) < 4)
            send_item(ACT_CLEAR, random_word(), 1'($urandom_range(0, 1)));
         pick = $urandom_range(0, 99);
         if (pool_fill > 0 && pick < 60) begin
            p = $urandom_range(0, pool_fill - 1);
            vec_len = pool_len[p];
            for (k = 0; k < vec_len; k++) vec_buf[k] = pool_words[p][k];
            if (pick >= 40) begin
               case ($urandom_range(0, 2))
                  0: if (vec_len > 1) vec_len--;
                  1: if (vec_len < VEC_BUF) begin
                     vec_buf[vec_len] = random_word();
                     vec_len++;
                  end
                  default: begin
                     k = $urandom_range(0, vec_len - 1);
                     vec_buf[k] = vec_buf[k] ^ (16'h0001 << $urandom_range(0, 15));
                  end
               endcase
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) vec_len = $urandom_range(1, 6);
            else if (pick < 93) vec_len = $urandom_range(7, 24);
            else if (pick < 98) vec_len = $urandom_range(VECTOR_MAX - 4, VECTOR_MAX);
            else vec_len = $urandom_range(VECTOR_MAX + 1, VECTOR_MAX + 3);
            for (k = 0; k < vec_len; k++) vec_buf[k] = random_word();
         end
         if ($urandom_range(0, 24) == 0) begin
            send_vector($urandom_range(0, vec_len - 1));
         end else begin
            send_vector(-1);
            p = (pool_fill < POOL_SIZE) ? pool_fill : $urandom_range(0, POOL_SIZE - 1);
            if (pool_fill < POOL_SIZE) pool_fill++;
            pool_len[p] = vec_len;
            for (k = 0; k < vec_len; k++) pool_words[p][k] = vec_buf[k];
         end
         if (!paused_once && items_sent >= random_goal - RANDOM_ITEMS / 2) begin
            paused_once = 1'b1;
            wait_results_drained();
         end
      end
      wait_results_drained();

      // identical vectors back to back, without stalls
      steady_phase = 1'b1;
      send_item(ACT_CLEAR, random_word(), 1'($urandom_range(0, 1)));
      for (i = 0; i < STEADY_VECTORS; i++) send_item(ACT_PUSH, 16'h0000, 1'b1);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d clears), checked %0d results.", items_sent, clears_sent,
               results_seen);
      $display("Status mix: %0d matched, %0d new, %0d table full, %0d too long.",
               status_hits[STATUS_MATCH], status_hits[STATUS_NEW], status_hits[STATUS_FULL],
               status_hits[STATUS_LONG]);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/evdt_pkg.sv
rtl/evdt_ram.sv
rtl/exact_vector_dedup_table.sv
test/tb_exact_vector_dedup_table.sv
